>>> rtl/bfcd_pkg.sv
// ---------------------------------------------------------------------------
// bfcd_pkg
// Shared types and constants for the banked flash command device: command
// phase codes, unlock addresses and bytes, and controller/datapath links.
// ---------------------------------------------------------------------------
package bfcd_pkg;

  // command sequence phases
  localparam logic [2:0] PH_IDLE          = 3'd0;
  localparam logic [2:0] PH_UNLOCK1       = 3'd1;
  localparam logic [2:0] PH_COMMAND       = 3'd2;
  localparam logic [2:0] PH_ERASE_UNLOCK0 = 3'd3;
  localparam logic [2:0] PH_ERASE_UNLOCK1 = 3'd4;
  localparam logic [2:0] PH_ERASE_CONFIRM = 3'd5;
  localparam logic [2:0] PH_BANK          = 3'd6;
  localparam logic [2:0] PH_PROGRAM       = 3'd7;

  // access kinds
  localparam logic ACC_READ  = 1'b0;
  localparam logic ACC_WRITE = 1'b1;

  // unlock addresses and bytes
  localparam logic [15:0] ADDR_UNLOCK_A = 16'h5555;
  localparam logic [15:0] ADDR_UNLOCK_B = 16'h2AAA;
  localparam logic [15:0] ADDR_BANK_SEL = 16'h0000;
  localparam logic [7:0]  BYTE_UNLOCK_A = 8'hAA;
  localparam logic [7:0]  BYTE_UNLOCK_B = 8'h55;
  localparam logic [7:0]  OP_ERASE      = 8'h80;
  localparam logic [7:0]  OP_BANK       = 8'hB0;
  localparam logic [7:0]  OP_PROGRAM    = 8'hA0;
  localparam logic [7:0]  OP_CHIP_ERASE = 8'h10;
  localparam logic [7:0]  ERASED_BYTE   = 8'hFF;

  // controller to datapath
  typedef struct packed {
    logic load_item;
    logic commit;
    logic clear_en;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_last;
    logic erase_req;
    logic out_free;
  } dp_status_t;

endpackage

>>> rtl/bfcd_ctrl.sv
// ---------------------------------------------------------------------------
// bfcd_ctrl
// Sequencing state machine: accepts a request, walks it through the address
// reduction and memory read steps, commits it, and runs the clearing pass.
// ---------------------------------------------------------------------------
module bfcd_ctrl
  import bfcd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_QUOT  = 3'd2;
  localparam logic [2:0] S_REM   = 3'd3;
  localparam logic [2:0] S_ADDR  = 3'd4;
  localparam logic [2:0] S_READ  = 3'd5;
  localparam logic [2:0] S_EXEC  = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_stall      = (state != S_IDLE);
  assign cmd.load_item = (state == S_IDLE) && in_valid;
  assign cmd.commit    = (state == S_EXEC) && status.out_free;
  assign cmd.clear_en  = (state == S_CLEAR);

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (status.clear_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) state_next = S_QUOT;
      end
      S_QUOT:  state_next = S_REM;
      S_REM:   state_next = S_ADDR;
      S_ADDR:  state_next = S_READ;
      S_READ:  state_next = S_EXEC;
      S_EXEC: begin
        if (status.out_free) state_next = status.erase_req ? S_CLEAR : S_IDLE;
      end
      default: state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  a_reset_clears: assert property (@(posedge clk) rst |=> state == S_CLEAR)
    else $error("reset did not start the clearing pass");

  a_accept_steps: assert property (@(posedge clk) disable iff (rst)
    cmd.load_item |=> state == S_QUOT)
    else $error("accepted request did not enter address reduction");

endmodule

>>> rtl/bfcd_datapath.sv
// ---------------------------------------------------------------------------
// bfcd_datapath
// Request registers, command phase tracker, bank register, address
// reduction, flash array with clearing cursor, and the result register.
// ---------------------------------------------------------------------------
module bfcd_datapath
  import bfcd_pkg::*;
#(
  parameter int BANK_BYTES = 65536,
  parameter int NUM_BANKS  = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  ctrl_cmd_t   cmd,
  output dp_status_t  status,
  input  logic        acc,
  input  logic [15:0] addr,
  input  logic [7:0]  wdata,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  rdata,
  output logic        seq_error
);

  localparam int STORE_BYTES = NUM_BANKS * BANK_BYTES;
  localparam int IDX_W       = $clog2(STORE_BYTES);
  localparam int OFF_W       = $clog2(BANK_BYTES);
  localparam int RECIP_W     = 33 - OFF_W;
  localparam int Q_W         = 17 - OFF_W;
  localparam int PROD_W      = 16 + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << 32) / BANK_BYTES);

  // request registers
  logic        acc_q;
  logic [15:0] addr_q;
  logic [7:0]  wdata_q;

  // sequence state
  logic [2:0] cmd_phase;
  logic       bank_select;

  // address reduction
  logic [PROD_W-1:0] prod;
  logic [Q_W-1:0]    quot;
  logic [16:0]       rem_full;
  logic [OFF_W:0]    rem_raw;
  logic [OFF_W:0]    rem_sub;
  logic [OFF_W-1:0]  offset;
  logic [IDX_W-1:0]  idx_next;
  logic [IDX_W-1:0]  idx_q;

  // array
  logic [7:0]       mem [STORE_BYTES];
  logic [7:0]       mem_q;
  logic [IDX_W-1:0] cursor;

  // decode
  logic [2:0] phase_next;
  logic       err;
  logic       bank_wr;
  logic       do_prog;
  logic       do_erase;
  logic       bank_value;

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      acc_q   <= acc;
      addr_q  <= addr;
      wdata_q <= wdata;
    end
  end

  // offset = addr mod BANK_BYTES by reciprocal, quotient may be one short
  assign prod     = PROD_W'(addr_q) * PROD_W'(RECIP);
  assign rem_full = {1'b0, addr_q} - 17'(quot * BANK_BYTES);
  assign rem_sub  = rem_raw - (OFF_W+1)'(BANK_BYTES);
  assign offset   = (rem_raw >= (OFF_W+1)'(BANK_BYTES)) ? rem_sub[OFF_W-1:0]
                                                        : rem_raw[OFF_W-1:0];
  assign idx_next = IDX_W'(offset) + (bank_select ? IDX_W'(BANK_BYTES) : '0);

  always_ff @(posedge clk) begin
    quot    <= prod[PROD_W-1:32];
    rem_raw <= rem_full[OFF_W:0];
    idx_q   <= idx_next;
  end

  assign bank_value = (NUM_BANKS > 1) ? wdata_q[0] : 1'b0;

  always_comb begin
    phase_next = PH_IDLE;
    err        = 1'b0;
    bank_wr    = 1'b0;
    do_prog    = 1'b0;
    do_erase   = 1'b0;
    if (acc_q == ACC_READ) begin
      phase_next = cmd_phase;
    end else begin
      case (cmd_phase)
        PH_IDLE: begin
          if (addr_q == ADDR_UNLOCK_A && wdata_q == BYTE_UNLOCK_A) phase_next = PH_UNLOCK1;
          else err = 1'b1;
        end
        PH_UNLOCK1: begin
          if (addr_q == ADDR_UNLOCK_B && wdata_q == BYTE_UNLOCK_B) phase_next = PH_COMMAND;
          else err = 1'b1;
        end
        PH_COMMAND: begin
          if (addr_q != ADDR_UNLOCK_A) err = 1'b1;
          else if (wdata_q == OP_ERASE) phase_next = PH_ERASE_UNLOCK0;
          else if (wdata_q == OP_BANK) phase_next = PH_BANK;
          else if (wdata_q == OP_PROGRAM) phase_next = PH_PROGRAM;
          else err = 1'b1;
        end
        PH_ERASE_UNLOCK0: begin
          if (addr_q == ADDR_UNLOCK_A && wdata_q == BYTE_UNLOCK_A) begin
            phase_next = PH_ERASE_UNLOCK1;
          end else begin
            err = 1'b1;
          end
        end
        PH_ERASE_UNLOCK1: begin
          if (addr_q == ADDR_UNLOCK_B && wdata_q == BYTE_UNLOCK_B) begin
            phase_next = PH_ERASE_CONFIRM;
          end else begin
            err = 1'b1;
          end
        end
        PH_ERASE_CONFIRM: begin
          if (addr_q == ADDR_UNLOCK_A && wdata_q == OP_CHIP_ERASE) do_erase = 1'b1;
          else err = 1'b1;
        end
        PH_BANK: begin
          if (addr_q == ADDR_BANK_SEL) bank_wr = 1'b1;
          else err = 1'b1;
        end
        default: begin
          do_prog = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_phase   <= PH_IDLE;
      bank_select <= 1'b0;
    end else if (cmd.commit) begin
      cmd_phase <= phase_next;
      if (bank_wr) bank_select <= bank_value;
    end
  end

  // flash array: one write port shared by the clearing pass and programming
  always_ff @(posedge clk) begin
    if (cmd.clear_en) begin
      mem[cursor] <= ERASED_BYTE;
    end else if (cmd.commit && do_prog) begin
      mem[idx_q] <= mem_q & wdata_q;
    end
    mem_q <= mem[idx_q];
  end

  assign status.clear_last = (cursor == IDX_W'(STORE_BYTES - 1));
  assign status.erase_req  = do_erase;
  assign status.out_free   = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor <= '0;
    end else if (cmd.clear_en) begin
      cursor <= status.clear_last ? '0 : cursor + 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      rdata     <= (acc_q == ACC_READ) ? mem_q : 8'h00;
      seq_error <= err;
    end
  end

  a_commit_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> out_valid)
    else $error("committed request produced no result");

  a_cursor_walks: assert property (@(posedge clk) disable iff (rst)
    cmd.clear_en && !status.clear_last |=> cursor == IDX_W'($past(cursor) + 1'b1))
    else $error("clearing cursor skipped an entry");

  a_read_no_error: assert property (@(posedge clk) disable iff (rst)
    out_valid && rdata != 8'h00 |-> !seq_error)
    else $error("read result flagged a sequence error");

endmodule

>>> rtl/banked_flash_command_device.sv
// ---------------------------------------------------------------------------
// banked_flash_command_device
// Byte-wide banked flash with an unlock/command sequence interface.
// ---------------------------------------------------------------------------
// Each request is one bus access (read or write of one byte) and gives one
// result. From acceptance to its result being loaded in the output register
// a request passes through these steps: two form the quotient and remainder
// of the address by the bank size, one corrects the remainder and registers
// the array index, one reads the array, and in the last the request
// commits, once the output register is free. The next request can be
// accepted in the cycle after the commit unless a chip erase follows; no
// new request is taken while one is in flight. After reset, and after a chip
// erase command, all NUM_BANKS*BANK_BYTES bytes (131072 at the defaults) are
// refilled with 0xFF one byte per cycle, and in_stall stays high meanwhile.
// ---------------------------------------------------------------------------
module banked_flash_command_device
  import bfcd_pkg::*;
#(
  parameter int BANK_BYTES = 65536,
  parameter int NUM_BANKS  = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        cmd,
  input  logic [15:0] addr,
  input  logic [7:0]  wdata,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  rdata,
  output logic        seq_error
);

  ctrl_cmd_t  ctrl_cmd;
  dp_status_t dp_status;

  bfcd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (dp_status),
    .cmd      (ctrl_cmd)
  );

  bfcd_datapath #(
    .BANK_BYTES (BANK_BYTES),
    .NUM_BANKS  (NUM_BANKS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (ctrl_cmd),
    .status    (dp_status),
    .acc       (cmd),
    .addr      (addr),
    .wdata     (wdata),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .rdata     (rdata),
    .seq_error (seq_error)
  );

endmodule
